// ===== rtl/xps_pkg.sv =====
// Shared types, constants and helper functions for the XMODEM packet sender.
// No dependencies; used by every other file in rtl/.
package xps_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int STORE_AW      = $clog2(PAYLOAD_BYTES);
    localparam int FRAME_LEN_CRC = PAYLOAD_BYTES + 5;
    localparam int FRAME_LEN_SUM = PAYLOAD_BYTES + 4;
    localparam int CHECK_HI_POS  = PAYLOAD_BYTES + 3;

    // input modes
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_HOST    = 3'd1;
    localparam logic [2:0] MODE_TICK    = 3'd2;
    localparam logic [2:0] MODE_PAYLOAD = 3'd3;
    localparam logic [2:0] MODE_SLOT    = 3'd4;

    // protocol characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    // status codes
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;
    localparam logic [2:0] ST_RETRY     = 3'd5;
    localparam logic [2:0] ST_FETCH_ERR = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_TOTAL_SIZE    = 3'd0;
    localparam logic [2:0] CFG_BASE_ADDRESS  = 3'd1;
    localparam logic [2:0] CFG_FORCE_CRC     = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [2:0] CFG_RETRY_LIMIT   = 3'd4;

    localparam int CFG_DATA_W = 17;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_START,
        PH_FETCH,
        PH_SEND,
        PH_WAIT_RESP,
        PH_DONE,
        PH_CANCEL,
        PH_TIMEOUT,
        PH_RETRY,
        PH_FETCH_ERR
    } phase_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] host_byte;
        logic [7:0] payload_byte;
        logic       fetch_failed;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic [7:0]  fetch_length;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic [16:0] total_size;
        logic [15:0] base_address;
        logic        force_crc;
        logic [15:0] timeout_ticks;
        logic [7:0]  retry_limit;
    } cfg_t;

    function automatic logic [2:0] status_of(input phase_t ph);
        logic [2:0] st;
        unique case (ph)
            PH_IDLE:      st = ST_IDLE;
            PH_DONE:      st = ST_DONE;
            PH_CANCEL:    st = ST_CANCELLED;
            PH_TIMEOUT:   st = ST_TIMEOUT;
            PH_RETRY:     st = ST_RETRY;
            PH_FETCH_ERR: st = ST_FETCH_ERR;
            default:      st = ST_BUSY;
        endcase
        return st;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/xps_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on xps_pkg.
interface xps_item_if
    import xps_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] host_byte;
    logic [7:0] payload_byte;
    logic       fetch_failed;

    modport source (output valid, mode, host_byte, payload_byte, fetch_failed, input ready);
    modport sink   (input valid, mode, host_byte, payload_byte, fetch_failed, output ready);
endinterface

interface xps_result_if
    import xps_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic [7:0]  fetch_length;
    logic [2:0]  status;

    modport source (output valid, tx_valid, tx_byte, fetch_request, fetch_address,
                    fetch_length, status, input ready);
    modport sink   (input valid, tx_valid, tx_byte, fetch_request, fetch_address,
                    fetch_length, status, output ready);
endinterface

// ===== rtl/xps_store.sv =====
// Packet payload store: one write port, one read port with registered data.
// Depends on xps_pkg.
module xps_store
    import xps_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [STORE_AW-1:0] waddr,
    input  logic [7:0]          wdata,
    input  logic [STORE_AW-1:0] raddr,
    output logic [7:0]          rdata
);

    logic [7:0] mem [PAYLOAD_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/xps_check.sv =====
// Running frame check: one CRC-16 or 8-bit checksum step per payload byte.
// Depends on xps_pkg.
module xps_check
    import xps_pkg::*;
(
    input  logic [15:0] check,
    input  logic        use_crc,
    input  logic [7:0]  data,
    output logic [15:0] check_next
);

    logic [7:0] sum;

    assign sum = check[7:0] + data;

    always_comb
    begin
        if (use_crc)
            check_next = crc16_byte(check, data);
        else
            check_next = {8'h00, sum};
    end

endmodule

// ===== rtl/xps_ctrl.sv =====
// Protocol sequencer: transfer state, framing and result formation per item.
// Depends on xps_pkg, xps_store and xps_check.
module xps_ctrl
    import xps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t      phase_reg,  phase_next;
    logic [15:0] pn_reg,     pn_next;
    logic [16:0] br_reg,     br_next;
    logic [7:0]  retry_reg,  retry_next;
    logic [15:0] wait_reg,   wait_next;
    logic        crc_reg,    crc_next;
    logic [7:0]  bp_reg,     bp_next;
    logic [15:0] chk_reg,    chk_next;

    logic                store_we;
    logic [STORE_AW-1:0] store_raddr;
    logic [7:0]          store_rdata;
    logic [15:0]         chk_step;
    logic                do_fetch;
    logic [15:0]         pn_less;
    logic [7:0]          rd_ptr;
    logic                host_cancel;

    xps_store u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (bp_reg[STORE_AW-1:0]),
        .wdata (item.payload_byte),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    xps_check u_check (
        .check      (chk_reg),
        .use_crc    (crc_reg),
        .data       (item.payload_byte),
        .check_next (chk_step)
    );

    // next send position is read ahead so the data is registered in time
    assign rd_ptr      = (advance ? bp_next : bp_reg) - 8'd3;
    assign store_raddr = rd_ptr[STORE_AW-1:0];
    assign host_cancel = (item.host_byte == CH_ETX) || (item.host_byte == CH_CAN);
    assign pn_less     = pn_next - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pn_reg    <= 16'd1;
            br_reg    <= '0;
            retry_reg <= '0;
            wait_reg  <= '0;
            crc_reg   <= 1'b0;
            bp_reg    <= '0;
            chk_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pn_reg    <= pn_next;
            br_reg    <= br_next;
            retry_reg <= retry_next;
            wait_reg  <= wait_next;
            crc_reg   <= crc_next;
            bp_reg    <= bp_next;
            chk_reg   <= chk_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pn_next    = pn_reg;
        br_next    = br_reg;
        retry_next = retry_reg;
        wait_next  = wait_reg;
        crc_next   = crc_reg;
        bp_next    = bp_reg;
        chk_next   = chk_reg;
        store_we   = 1'b0;
        do_fetch   = 1'b0;
        res        = '0;

        if (advance)
        begin
            priority if (item.mode == MODE_START)
            begin
                pn_next    = 16'd1;
                br_next    = cfg.total_size;
                retry_next = '0;
                wait_next  = '0;
                crc_next   = 1'b0;
                bp_next    = '0;
                chk_next   = '0;
                phase_next = PH_WAIT_START;
            end
            else if (phase_reg == PH_WAIT_START)
            begin
                if (item.mode == MODE_HOST)
                begin
                    if (host_cancel)
                        phase_next = PH_CANCEL;
                    else if (item.host_byte == CH_C ||
                             (!cfg.force_crc && item.host_byte == CH_NAK))
                    begin
                        crc_next = cfg.force_crc || (item.host_byte == CH_C);
                        do_fetch = 1'b1;
                    end
                end
                else if (item.mode == MODE_TICK)
                begin
                    if (wait_reg == cfg.timeout_ticks)
                        phase_next = PH_TIMEOUT;
                    else
                        wait_next = wait_reg + 16'd1;
                end
            end
            else if (phase_reg == PH_FETCH)
            begin
                if (item.mode == MODE_PAYLOAD)
                begin
                    if (item.fetch_failed)
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = CH_EOT;
                        phase_next   = PH_FETCH_ERR;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        chk_next = chk_step;
                        if (bp_reg == 8'(PAYLOAD_BYTES - 1))
                        begin
                            bp_next    = '0;
                            phase_next = PH_SEND;
                        end
                        else
                            bp_next = bp_reg + 8'd1;
                    end
                end
            end
            else if (phase_reg == PH_SEND)
            begin
                if (item.mode == MODE_SLOT)
                begin
                    res.tx_valid = 1'b1;
                    priority if (bp_reg == 8'd0)
                        res.tx_byte = CH_SOH;
                    else if (bp_reg == 8'd1)
                        res.tx_byte = pn_reg[7:0];
                    else if (bp_reg == 8'd2)
                        res.tx_byte = ~pn_reg[7:0];
                    else if (bp_reg < 8'(CHECK_HI_POS))
                        res.tx_byte = store_rdata;
                    else if (bp_reg == 8'(CHECK_HI_POS) && crc_reg)
                        res.tx_byte = chk_reg[15:8];
                    else
                        res.tx_byte = chk_reg[7:0];
                    if (bp_reg + 8'd1 >= (crc_reg ? 8'(FRAME_LEN_CRC) : 8'(FRAME_LEN_SUM)))
                    begin
                        bp_next    = '0;
                        wait_next  = '0;
                        phase_next = PH_WAIT_RESP;
                    end
                    else
                        bp_next = bp_reg + 8'd1;
                end
            end
            else if (phase_reg == PH_WAIT_RESP)
            begin
                if (item.mode == MODE_HOST)
                begin
                    if (host_cancel)
                        phase_next = PH_CANCEL;
                    else if (item.host_byte == CH_ACK)
                    begin
                        pn_next = pn_reg + 16'd1;
                        br_next = (br_reg > 17'(PAYLOAD_BYTES)) ?
                                  br_reg - 17'(PAYLOAD_BYTES) : '0;
                        if (br_next == '0)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = CH_EOT;
                            wait_next    = '0;
                            phase_next   = PH_DONE;
                        end
                        else
                            do_fetch = 1'b1;
                    end
                    else if (item.host_byte == CH_NAK)
                    begin
                        wait_next = '0;
                        if (retry_reg < cfg.retry_limit)
                        begin
                            retry_next = retry_reg + 8'd1;
                            bp_next    = '0;
                            phase_next = PH_SEND;
                        end
                        else
                            phase_next = PH_RETRY;
                    end
                end
                else if (item.mode == MODE_TICK)
                begin
                    if (wait_reg == cfg.timeout_ticks)
                        phase_next = PH_TIMEOUT;
                    else
                        wait_next = wait_reg + 16'd1;
                end
            end
            else
            begin
            end

            if (do_fetch)
            begin
                res.fetch_request = 1'b1;
                res.fetch_address = cfg.base_address +
                                    {pn_less[15-STORE_AW:0], {STORE_AW{1'b0}}};
                res.fetch_length  = (br_next > 17'(PAYLOAD_BYTES)) ?
                                    8'(PAYLOAD_BYTES) : br_next[7:0];
                bp_next    = '0;
                chk_next   = '0;
                wait_next  = '0;
                phase_next = PH_FETCH;
            end

            res.status = status_of(phase_next);
        end
    end

    a_fetch_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FETCH |-> bp_reg < 8'(PAYLOAD_BYTES))
        else $error("fetch pointer beyond payload");

    a_send_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEND |-> bp_reg < 8'(FRAME_LEN_CRC))
        else $error("send pointer beyond frame");

    a_fetch_enters: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.fetch_request |=> phase_reg == PH_FETCH && bp_reg == 8'd0)
        else $error("fetch request without fetch phase");

    a_slot_sends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_SEND && item.mode == MODE_SLOT |-> res.tx_valid)
        else $error("transmit slot in send phase gave no byte");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        res.tx_valid |-> !res.fetch_request && advance)
        else $error("byte and fetch request in one result");

endmodule

// ===== rtl/xmodem_packet_sender.sv =====
// XMODEM packet sender top level. Each accepted transfer on item_in yields exactly one
// transfer on result_out, in order. An item is registered on input, processed
// combinationally against the transfer state, and its result registered on output;
// one item per cycle is sustained while result_out is ready. The 128-byte packet
// store is read one position ahead so its registered read data is ready on each
// transmit slot. Configuration writes take effect at once.
// Depends on xps_pkg, xps_if and xps_ctrl.
module xmodem_packet_sender
    import xps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    xps_item_if.sink              item_in,
    xps_result_if.source          result_out,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    in_vld_reg;
    item_t   item_reg;
    logic    out_vld_reg;
    result_t out_reg;
    result_t res;
    logic    advance;

    assign advance       = in_vld_reg && (!out_vld_reg || result_out.ready);
    assign item_in.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_size    <= '0;
            cfg_reg.base_address  <= '0;
            cfg_reg.force_crc     <= 1'b0;
            cfg_reg.timeout_ticks <= 16'd80;
            cfg_reg.retry_limit   <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_SIZE:    cfg_reg.total_size    <= cfg_data;
                CFG_BASE_ADDRESS:  cfg_reg.base_address  <= cfg_data[15:0];
                CFG_FORCE_CRC:     cfg_reg.force_crc     <= cfg_data[0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[15:0];
                CFG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item_in.ready)
                in_vld_reg <= item_in.valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (result_out.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            item_reg.mode         <= item_in.mode;
            item_reg.host_byte    <= item_in.host_byte;
            item_reg.payload_byte <= item_in.payload_byte;
            item_reg.fetch_failed <= item_in.fetch_failed;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    xps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign result_out.valid         = out_vld_reg;
    assign result_out.tx_valid      = out_reg.tx_valid;
    assign result_out.tx_byte       = out_reg.tx_byte;
    assign result_out.fetch_request = out_reg.fetch_request;
    assign result_out.fetch_address = out_reg.fetch_address;
    assign result_out.fetch_length  = out_reg.fetch_length;
    assign result_out.status        = out_reg.status;

endmodule

// ===== tb/tb_xmodem_packet_sender.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for xmodem_packet_sender: a directed table, then random XMODEM sessions.
// Every response is checked against the table's expected result or a local model of the sender.
// Depends on xps_pkg, xps_if and the block itself.
module tb_xmodem_packet_sender
    import xps_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEGMENT_ITEMS  = 440;
    localparam int DIRECTED_ROWS  = 25;
    localparam int CFG_SWITCH_ROW = 19;

    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } directed_row_t;

    localparam result_t UNTYPED         = '0;
    localparam result_t QUIET_IDLE      = '{1'b0, 8'h00, 1'b0, 16'h0000, 8'h00, ST_IDLE};
    localparam result_t QUIET_BUSY      = '{1'b0, 8'h00, 1'b0, 16'h0000, 8'h00, ST_BUSY};
    localparam result_t QUIET_CANCELLED = '{1'b0, 8'h00, 1'b0, 16'h0000, 8'h00, ST_CANCELLED};

    localparam directed_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{'{MODE_HOST,    CH_C,   8'h00, 1'b0}, 1'b1, QUIET_IDLE},
        '{'{3'd7,         8'hFF,  8'hFF, 1'b1}, 1'b1, QUIET_IDLE},
        '{'{3'd5,         8'h00,  8'h00, 1'b0}, 1'b1, QUIET_IDLE},
        '{'{MODE_PAYLOAD, 8'h00,  8'hFF, 1'b1}, 1'b1, QUIET_IDLE},
        '{'{MODE_SLOT,    8'h00,  8'h00, 1'b0}, 1'b1, QUIET_IDLE},
        '{'{MODE_TICK,    8'h00,  8'h00, 1'b0}, 1'b1, QUIET_IDLE},
        '{'{MODE_START,   8'hFF,  8'hAA, 1'b1}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    CH_CAN, 8'h00, 1'b0}, 1'b1, QUIET_CANCELLED},
        '{'{MODE_TICK,    8'h00,  8'h00, 1'b0}, 1'b1, QUIET_CANCELLED},
        '{'{MODE_START,   8'h00,  8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    CH_ETX, 8'h00, 1'b0}, 1'b1, QUIET_CANCELLED},
        '{'{MODE_START,   8'h00,  8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    8'h00,  8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    CH_NAK, 8'h00, 1'b0}, 1'b1,
          '{1'b0, 8'h00, 1'b1, 16'h0000, 8'h00, ST_BUSY}},
        '{'{MODE_HOST,    CH_ACK, 8'h00, 1'b0}, 1'b0, UNTYPED},
        '{'{MODE_SLOT,    8'h00,  8'h00, 1'b0}, 1'b0, UNTYPED},
        '{'{MODE_PAYLOAD, 8'h00,  8'hFF, 1'b0}, 1'b0, UNTYPED},
        '{'{MODE_PAYLOAD, 8'h00,  8'h5A, 1'b1}, 1'b1,
          '{1'b1, CH_EOT, 1'b0, 16'h0000, 8'h00, ST_FETCH_ERR}},
        '{'{MODE_PAYLOAD, 8'h00,  8'h12, 1'b0}, 1'b0, UNTYPED},
        '{'{MODE_START,   8'h00,  8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    CH_NAK, 8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_TICK,    8'h00,  8'h00, 1'b0}, 1'b1,
          '{1'b0, 8'h00, 1'b0, 16'h0000, 8'h00, ST_TIMEOUT}},
        '{'{MODE_START,   8'h00,  8'h00, 1'b0}, 1'b1, QUIET_BUSY},
        '{'{MODE_HOST,    CH_C,   8'h00, 1'b0}, 1'b1,
          '{1'b0, 8'h00, 1'b1, 16'hFFFF, 8'd128, ST_BUSY}},
        '{'{MODE_PAYLOAD, 8'h00,  8'h00, 1'b0}, 1'b0, UNTYPED}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    xps_item_if   item_ch ();
    xps_result_if result_ch ();

    xmodem_packet_sender dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // sender model
    cfg_t        regs = '{17'd0, 16'd0, 1'b0, 16'd80, 8'd10};
    phase_t      model_phase = PH_IDLE;
    logic [15:0] pkt_num = 16'd1;
    logic [16:0] bytes_left = '0;
    logic [7:0]  resend_count = '0;
    logic [15:0] tick_count = '0;
    logic        crc_mode = 1'b0;
    logic [7:0]  payload_copy [PAYLOAD_BYTES];
    int          frame_pos = 0;
    logic [15:0] check_acc = '0;

    result_t     pending [$];
    int          fails = 0;
    int unsigned src_idle_pct = 26;
    int unsigned snk_idle_pct = 75;
    int          quiet_cycles = 0;
    bit          host_silent = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ data[k];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [2:0] status_code(input phase_t p);
        case (p)
            PH_IDLE:      return ST_IDLE;
            PH_DONE:      return ST_DONE;
            PH_CANCEL:    return ST_CANCELLED;
            PH_TIMEOUT:   return ST_TIMEOUT;
            PH_RETRY:     return ST_RETRY;
            PH_FETCH_ERR: return ST_FETCH_ERR;
            default:      return ST_BUSY;
        endcase
    endfunction

    function automatic void request_packet(inout result_t r);
        r.fetch_request = 1'b1;
        r.fetch_address = regs.base_address + (pkt_num - 16'd1) * 16'd128;
        r.fetch_length  = (bytes_left > 17'd128) ? 8'd128 : bytes_left[7:0];
        frame_pos   = 0;
        check_acc   = '0;
        tick_count  = '0;
        model_phase = PH_FETCH;
    endfunction

    function automatic void count_tick();
        if (tick_count == regs.timeout_ticks)
            model_phase = PH_TIMEOUT;
        else
            tick_count = tick_count + 16'd1;
    endfunction

    function automatic result_t sender_response(input item_t stim);
        result_t r;
        int      frame_len;
        r = '0;
        if (stim.mode == MODE_START)
        begin
            pkt_num      = 16'd1;
            bytes_left   = regs.total_size;
            resend_count = '0;
            tick_count   = '0;
            crc_mode     = 1'b0;
            frame_pos    = 0;
            check_acc    = '0;
            model_phase  = PH_WAIT_START;
        end
        else
        begin
            case (model_phase)
                PH_WAIT_START:
                begin
                    if (stim.mode == MODE_HOST)
                    begin
                        if (stim.host_byte == CH_ETX || stim.host_byte == CH_CAN)
                            model_phase = PH_CANCEL;
                        else if (stim.host_byte == CH_C
                                 || (!regs.force_crc && stim.host_byte == CH_NAK))
                        begin
                            crc_mode = regs.force_crc || stim.host_byte == CH_C;
                            request_packet(r);
                        end
                    end
                    else if (stim.mode == MODE_TICK)
                        count_tick();
                end
                PH_FETCH:
                begin
                    if (stim.mode == MODE_PAYLOAD)
                    begin
                        if (stim.fetch_failed)
                        begin
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = CH_EOT;
                            model_phase = PH_FETCH_ERR;
                        end
                        else
                        begin
                            payload_copy[frame_pos] = stim.payload_byte;
                            if (crc_mode)
                                check_acc = crc_next(check_acc, stim.payload_byte);
                            else
                                check_acc = {8'h00, check_acc[7:0] + stim.payload_byte};
                            frame_pos++;
                            if (frame_pos == PAYLOAD_BYTES)
                            begin
                                frame_pos   = 0;
                                model_phase = PH_SEND;
                            end
                        end
                    end
                end
                PH_SEND:
                begin
                    if (stim.mode == MODE_SLOT)
                    begin
                        frame_len  = crc_mode ? FRAME_LEN_CRC : FRAME_LEN_SUM;
                        r.tx_valid = 1'b1;
                        if (frame_pos == 0)
                            r.tx_byte = CH_SOH;
                        else if (frame_pos == 1)
                            r.tx_byte = pkt_num[7:0];
                        else if (frame_pos == 2)
                            r.tx_byte = ~pkt_num[7:0];
                        else if (frame_pos < PAYLOAD_BYTES + 3)
                            r.tx_byte = payload_copy[frame_pos - 3];
                        else if (frame_pos == CHECK_HI_POS)
                            r.tx_byte = crc_mode ? check_acc[15:8] : check_acc[7:0];
                        else
                            r.tx_byte = check_acc[7:0];
                        frame_pos++;
                        if (frame_pos >= frame_len)
                        begin
                            frame_pos   = 0;
                            tick_count  = '0;
                            model_phase = PH_WAIT_RESP;
                        end
                    end
                end
                PH_WAIT_RESP:
                begin
                    if (stim.mode == MODE_HOST)
                    begin
                        if (stim.host_byte == CH_ETX || stim.host_byte == CH_CAN)
                            model_phase = PH_CANCEL;
                        else if (stim.host_byte == CH_ACK)
                        begin
                            pkt_num    = pkt_num + 16'd1;
                            bytes_left = (bytes_left > 17'd128) ? bytes_left - 17'd128 : '0;
                            if (bytes_left == '0)
                            begin
                                r.tx_valid  = 1'b1;
                                r.tx_byte   = CH_EOT;
                                tick_count  = '0;
                                model_phase = PH_DONE;
                            end
                            else
                                request_packet(r);
                        end
                        else if (stim.host_byte == CH_NAK)
                        begin
                            tick_count = '0;
                            if (resend_count < regs.retry_limit)
                            begin
                                resend_count = resend_count + 8'd1;
                                frame_pos    = 0;
                                model_phase  = PH_SEND;
                            end
                            else
                                model_phase = PH_RETRY;
                        end
                    end
                    else if (stim.mode == MODE_TICK)
                        count_tick();
                end
                default:
                begin
                end
            endcase
        end
        r.status = status_code(model_phase);
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // mostly well-formed session traffic chosen from the model's phase, with some noise
    task automatic pick_item(output item_t stim, output bit counted);
        int unsigned roll;
        roll               = $urandom_range(99);
        counted            = 1'b1;
        stim.mode          = 3'($urandom_range(1, 7));
        stim.host_byte     = 8'($urandom);
        stim.payload_byte  = rand_byte();
        stim.fetch_failed  = 1'($urandom_range(0, 1));
        case (model_phase)
            PH_WAIT_START, PH_WAIT_RESP:
            begin
                if (host_silent && roll < 80)
                    stim.mode = MODE_TICK;
                else if (roll < 4)
                begin
                    stim.mode      = MODE_HOST;
                    stim.host_byte = roll[0] ? CH_CAN : CH_ETX;
                end
                else if (roll < 14)
                    stim.mode = MODE_TICK;
                else if (roll < 92)
                begin
                    stim.mode = MODE_HOST;
                    if (model_phase == PH_WAIT_START)
                        stim.host_byte = ($urandom_range(99) < 65) ? CH_C : CH_NAK;
                    else
                        stim.host_byte = ($urandom_range(99) < 80) ? CH_ACK : CH_NAK;
                end
                else
                    counted = 1'b0;
            end
            PH_FETCH:
            begin
                if (roll < 95)
                    stim.mode = MODE_PAYLOAD;
                else
                    counted = 1'b0;
            end
            PH_SEND:
            begin
                if (roll < 95)
                    stim.mode = MODE_SLOT;
                else
                    counted = 1'b0;
            end
            default:
            begin
                if (roll < 85)
                    stim.mode = MODE_START;
                else
                    counted = 1'b0;
            end
        endcase
        if ($urandom_range(0, 599) == 0)
            stim.mode = MODE_START;
        if (stim.mode == MODE_PAYLOAD)
            stim.fetch_failed = ($urandom_range(0, 1499) == 0);
        if (stim.mode == MODE_START)
            host_silent = ($urandom_range(99) < 15);
    endtask

    task automatic send_item(input item_t stim, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= stim.mode;
        item_ch.host_byte    <= stim.host_byte;
        item_ch.payload_byte <= stim.payload_byte;
        item_ch.fetch_failed <= stim.fetch_failed;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = sender_response(stim);
        pending.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOTAL_SIZE;
        cfg_data  <= c.total_size;
        @(posedge clk);
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_data  <= CFG_DATA_W'(c.base_address);
        @(posedge clk);
        cfg_index <= CFG_FORCE_CRC;
        cfg_data  <= CFG_DATA_W'(c.force_crc);
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= CFG_DATA_W'(c.timeout_ticks);
        @(posedge clk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= CFG_DATA_W'(c.retry_limit);
        @(posedge clk);
        cfg_we <= 1'b0;
        regs = c;
    endtask

    task automatic compare(input string field, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending.size() == 0)
            begin
                $error("result transfer with no response outstanding");
                fails++;
            end
            else
            begin
                want = pending.pop_front();
                compare("tx_valid", 16'(want.tx_valid), 16'(result_ch.tx_valid));
                compare("tx_byte", 16'(want.tx_byte), 16'(result_ch.tx_byte));
                compare("fetch_request", 16'(want.fetch_request), 16'(result_ch.fetch_request));
                compare("fetch_address", want.fetch_address, result_ch.fetch_address);
                compare("fetch_length", 16'(want.fetch_length), 16'(result_ch.fetch_length));
                compare("status", 16'(want.status), 16'(result_ch.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        item_t stim;
        bit    counted;
        int    segment_count;
        cfg_t  setting;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        item_ch.valid        = 1'b0;
        item_ch.mode         = MODE_START;
        item_ch.host_byte    = '0;
        item_ch.payload_byte = '0;
        item_ch.fetch_failed = 1'b0;
        foreach (payload_copy[i])
            payload_copy[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == CFG_SWITCH_ROW)
            begin
                wait_drained();
                load_settings('{17'd65536, 16'hFFFF, 1'b1, 16'd0, 8'd0});
            end
            send_item(DIRECTED_STEPS[i].stim, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
        end

        for (int seg = 0; seg < 3; seg++)
        begin
            wait_drained();
            case (seg)
                0:
                begin
                    setting = '{17'($urandom_range(0, 300)), 16'($urandom), 1'b0,
                                16'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
                end
                1:
                begin
                    src_idle_pct = 75;
                    snk_idle_pct = 26;
                    setting = '{17'd65536, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF};
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    setting = '{17'd0, 16'($urandom), 1'($urandom_range(0, 1)),
                                16'($urandom_range(0, 6)), 8'($urandom_range(0, 2))};
                end
            endcase
            load_settings(setting);
            segment_count = 0;
            while (segment_count < SEGMENT_ITEMS)
            begin
                pick_item(stim, counted);
                send_item(stim, 1'b0, UNTYPED);
                if (counted)
                    segment_count++;
            end
        end

        wait_drained();
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xps_pkg.sv
rtl/xps_if.sv
rtl/xps_store.sv
rtl/xps_check.sv
rtl/xps_ctrl.sv
rtl/xmodem_packet_sender.sv
tb/tb_xmodem_packet_sender.sv
